/* src/rtt_pkg.sv */
// Shared constants for the ray and triangle intersection pipeline.
`timescale 1ns / 1ps

package rtt_pkg;

    localparam int FIELD_W         = 63;
    localparam int NUM_IN_FIELDS   = 6;
    localparam int IN_DATA_W       = ((FIELD_W * NUM_IN_FIELDS + 7) / 8) * 8;
    localparam int COORD_BITS_DEF  = 21;
    localparam int DIST_FRAC_BITS  = 16;
    localparam int DIST_BITS       = 32;

endpackage

/* src/ray_triangle_intersect.sv */
// Top level of the streaming ray and triangle intersection pipeline.
`timescale 1ns / 1ps

// One ray and triangle test is taken per clock cycle while the output is not held
// back. Each passes through five stages that form the plane terms, a 32-stage restoring
// divider that yields one bit of the Q16.16 distance per stage, and ten further stages
// that form the hit point, the test on each triangle edge and the output register. When the output
// beat is held back, the whole pipeline freezes, so nothing is dropped or repeated.

module ray_triangle_intersect #(
    parameter int COORD_BITS = rtt_pkg::COORD_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // ray_origin, ray_direction, vertex_a, vertex_b, vertex_c, plane_normal
    input  logic [rtt_pkg::IN_DATA_W-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // distance
    output logic [rtt_pkg::DIST_BITS-1:0] m_axis_tdata,
    // hit
    output logic [0:0] m_axis_tuser
);

    localparam int C    = COORD_BITS;
    localparam int FW   = rtt_pkg::FIELD_W;
    localparam int FRAC = rtt_pkg::DIST_FRAC_BITS;
    localparam int QB   = rtt_pkg::DIST_BITS;
    localparam int D1   = C + 1;
    localparam int NPW  = 2 * C + 1;
    localparam int DPW  = 2 * C;
    localparam int NUMW = 2 * C + 3;
    localparam int DENW = 2 * C + 2;
    localparam int XPW  = 2 * C + 2;
    localparam int C12W = 2 * C + 3;
    localparam int MW   = NUMW;
    localparam int SATW = MW + FRAC;
    localparam int TPW  = QB + 1 + C;
    localparam int IPW  = C + 18;
    localparam int VPW  = C + 19;
    localparam int QW   = D1 + VPW;
    localparam int CPW  = QW + 1;
    localparam int LB   = CPW / 2;
    localparam int HW   = CPW - LB;
    localparam int HPW  = C12W + HW;
    localparam int LPW  = C12W + LB + 1;
    localparam int DW   = C12W + CPW;
    localparam int SW   = DW + 2;

    localparam int NX1 [3] = '{1, 2, 0};
    localparam int NX2 [3] = '{2, 0, 1};

    typedef logic [2:0][C-1:0] vec_t;

    typedef struct packed {
        vec_t                          o;
        vec_t                          d;
        vec_t                          n;
        logic [2:0][2:0][C-1:0]        vt;
        logic [2:0][D1-1:0]            am;
        logic [2:0][2:0][D1-1:0]       e1;
        logic [2:0][2:0][D1-1:0]       e2;
        logic [2:0][NPW-1:0]           pn;
        logic [2:0][DPW-1:0]           pd;
        logic [2:0][2:0][XPW-1:0]      pa;
        logic [2:0][2:0][XPW-1:0]      pb;
        logic [NUMW-1:0]               num;
        logic [DENW-1:0]               den;
        logic [2:0][2:0][C12W-1:0]     c12;
        logic                          miss;
        logic                          sat;
        logic [MW-1:0]                 nmag;
        logic [MW-1:0]                 dmag;
        logic [QB-1:0]                 tq;
        logic [2:0][TPW-1:0]           tdp;
        logic [2:0][IPW-1:0]           ip;
        logic [2:0][2:0][VPW-1:0]      vp;
        logic [2:0][2:0][QW-1:0]       qa;
        logic [2:0][2:0][QW-1:0]       qb;
        logic [2:0][2:0][CPW-1:0]      c1p;
        logic [2:0][2:0][HPW-1:0]      hp;
        logic [2:0][2:0][LPW-1:0]      lp;
        logic [2:0][2:0][DW-1:0]       full;
        logic [2:0][SW-1:0]            s;
    } pipe_t;

    localparam int SIDE_W = $bits(pipe_t);

    pipe_t p1_reg, p1_next, p2_reg, p2_next, p3_reg, p3_next, p4_reg, p4_next;
    pipe_t p5_reg, p5_next, p6_reg, p6_next, p7_reg, p7_next, p8_reg, p8_next;
    pipe_t p9_reg, p9_next, p10_reg, p10_next, p11_reg, p11_next, p12_reg, p12_next;
    pipe_t p13_reg, p13_next, p14_reg, p14_next;

    logic [14:1]         vld_reg;
    logic                out_vld_reg;
    logic                hit_reg, hit_next;
    logic [QB-1:0]       dist_reg, dist_next;
    logic                adv;
    logic                div_vld;
    logic [QB-1:0]       div_quot;
    logic [SIDE_W-1:0]   div_side;
    pipe_t               div_pipe;
    logic [NUMW-1:0]     num_neg;
    logic [DENW-1:0]     den_neg;

    assign adv           = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = adv;

    always_comb
    begin
        p1_next = '0;
        for (int k = 0; k < 3; k++)
        begin
            p1_next.o[k]     = s_axis_tdata[0 * FW + k * C +: C];
            p1_next.d[k]     = s_axis_tdata[1 * FW + k * C +: C];
            p1_next.vt[0][k] = s_axis_tdata[2 * FW + k * C +: C];
            p1_next.vt[1][k] = s_axis_tdata[3 * FW + k * C +: C];
            p1_next.vt[2][k] = s_axis_tdata[4 * FW + k * C +: C];
            p1_next.n[k]     = s_axis_tdata[5 * FW + k * C +: C];
        end
    end

    always_comb
    begin
        p2_next = p1_reg;
        for (int k = 0; k < 3; k++)
        begin
            p2_next.am[k] = D1'($signed(p1_reg.vt[0][k])) - D1'($signed(p1_reg.o[k]));
            for (int e = 0; e < 3; e++)
            begin
                p2_next.e1[e][k] = D1'($signed(p1_reg.vt[NX1[e]][k]))
                                 - D1'($signed(p1_reg.vt[e][k]));
                p2_next.e2[e][k] = D1'($signed(p1_reg.vt[NX2[e]][k]))
                                 - D1'($signed(p1_reg.vt[e][k]));
            end
        end
    end

    always_comb
    begin
        p3_next = p2_reg;
        for (int k = 0; k < 3; k++)
        begin
            p3_next.pn[k] = NPW'($signed(p2_reg.n[k])) * NPW'($signed(p2_reg.am[k]));
            p3_next.pd[k] = DPW'($signed(p2_reg.n[k])) * DPW'($signed(p2_reg.d[k]));
            for (int e = 0; e < 3; e++)
            begin
                p3_next.pa[e][k] = XPW'($signed(p2_reg.e1[e][NX1[k]]))
                                 * XPW'($signed(p2_reg.e2[e][NX2[k]]));
                p3_next.pb[e][k] = XPW'($signed(p2_reg.e1[e][NX2[k]]))
                                 * XPW'($signed(p2_reg.e2[e][NX1[k]]));
            end
        end
    end

    always_comb
    begin
        p4_next     = p3_reg;
        p4_next.num = NUMW'($signed(p3_reg.pn[0])) + NUMW'($signed(p3_reg.pn[1]))
                    + NUMW'($signed(p3_reg.pn[2]));
        p4_next.den = DENW'($signed(p3_reg.pd[0])) + DENW'($signed(p3_reg.pd[1]))
                    + DENW'($signed(p3_reg.pd[2]));
        for (int e = 0; e < 3; e++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p4_next.c12[e][k] = C12W'($signed(p3_reg.pa[e][k]))
                                  - C12W'($signed(p3_reg.pb[e][k]));
            end
        end
    end

    always_comb
    begin
        p5_next      = p4_reg;
        num_neg      = ~p4_reg.num + 1'b1;
        den_neg      = ~p4_reg.den + 1'b1;
        p5_next.miss = (p4_reg.den == '0) || (p4_reg.num == '0)
                    || (p4_reg.num[NUMW-1] != p4_reg.den[DENW-1]);
        p5_next.nmag = p4_reg.num[NUMW-1] ? num_neg : p4_reg.num;
        p5_next.dmag = MW'(p4_reg.den[DENW-1] ? den_neg : p4_reg.den);
        p5_next.sat  = SATW'(p5_next.nmag) >= (SATW'(p5_next.dmag) << FRAC);
    end

    rtt_div #(
        .MW     (MW),
        .SIDE_W (SIDE_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (vld_reg[5]),
        .num       (p5_reg.nmag),
        .den       (p5_reg.dmag),
        .side_in   (p5_reg),
        .out_valid (div_vld),
        .quot      (div_quot),
        .side_out  (div_side)
    );

    assign div_pipe = pipe_t'(div_side);

    always_comb
    begin
        p6_next    = div_pipe;
        p6_next.tq = div_pipe.sat ? '1 : div_quot;
    end

    always_comb
    begin
        p7_next = p6_reg;
        for (int k = 0; k < 3; k++)
        begin
            p7_next.tdp[k] = TPW'($signed({1'b0, p6_reg.tq})) * TPW'($signed(p6_reg.d[k]));
        end
    end

    always_comb
    begin
        p8_next = p7_reg;
        for (int k = 0; k < 3; k++)
        begin
            p8_next.ip[k] = IPW'($signed(p7_reg.o[k]))
                          + IPW'($signed(p7_reg.tdp[k]) >>> FRAC);
        end
    end

    always_comb
    begin
        p9_next = p8_reg;
        for (int e = 0; e < 3; e++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p9_next.vp[e][k] = VPW'($signed(p8_reg.ip[k]))
                                 - VPW'($signed(p8_reg.vt[e][k]));
            end
        end
    end

    always_comb
    begin
        p10_next = p9_reg;
        for (int e = 0; e < 3; e++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p10_next.qa[e][k] = QW'($signed(p9_reg.e1[e][NX1[k]]))
                                  * QW'($signed(p9_reg.vp[e][NX2[k]]));
                p10_next.qb[e][k] = QW'($signed(p9_reg.e1[e][NX2[k]]))
                                  * QW'($signed(p9_reg.vp[e][NX1[k]]));
            end
        end
    end

    always_comb
    begin
        p11_next = p10_reg;
        for (int e = 0; e < 3; e++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p11_next.c1p[e][k] = CPW'($signed(p10_reg.qa[e][k]))
                                   - CPW'($signed(p10_reg.qb[e][k]));
            end
        end
    end

    always_comb
    begin
        p12_next = p11_reg;
        for (int e = 0; e < 3; e++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p12_next.hp[e][k] = HPW'($signed(p11_reg.c12[e][k]))
                                  * HPW'($signed(p11_reg.c1p[e][k][CPW-1:LB]));
                p12_next.lp[e][k] = LPW'($signed(p11_reg.c12[e][k]))
                                  * LPW'($signed({1'b0, p11_reg.c1p[e][k][LB-1:0]}));
            end
        end
    end

    always_comb
    begin
        p13_next = p12_reg;
        for (int e = 0; e < 3; e++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p13_next.full[e][k] = (DW'($signed(p12_reg.hp[e][k])) <<< LB)
                                    + DW'($signed(p12_reg.lp[e][k]));
            end
        end
    end

    always_comb
    begin
        p14_next = p13_reg;
        for (int e = 0; e < 3; e++)
        begin
            p14_next.s[e] = SW'($signed(p13_reg.full[e][0]))
                          + SW'($signed(p13_reg.full[e][1]))
                          + SW'($signed(p13_reg.full[e][2]));
        end
    end

    always_comb
    begin
        hit_next  = !p14_reg.miss && !p14_reg.s[0][SW-1] && !p14_reg.s[1][SW-1]
                 && !p14_reg.s[2][SW-1];
        dist_next = hit_next ? p14_reg.tq : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[1]    <= s_axis_tvalid;
            vld_reg[5:2]  <= vld_reg[4:1];
            vld_reg[6]    <= div_vld;
            vld_reg[14:7] <= vld_reg[13:6];
            out_vld_reg   <= vld_reg[14];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg   <= p1_next;
            p2_reg   <= p2_next;
            p3_reg   <= p3_next;
            p4_reg   <= p4_next;
            p5_reg   <= p5_next;
            p6_reg   <= p6_next;
            p7_reg   <= p7_next;
            p8_reg   <= p8_next;
            p9_reg   <= p9_next;
            p10_reg  <= p10_next;
            p11_reg  <= p11_next;
            p12_reg  <= p12_next;
            p13_reg  <= p13_next;
            p14_reg  <= p14_next;
            hit_reg  <= hit_next;
            dist_reg <= dist_next;
        end
    end

    assign m_axis_tvalid   = out_vld_reg;
    assign m_axis_tdata    = dist_reg;
    assign m_axis_tuser[0] = hit_reg;

    a_miss_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("missed ray carries a non-zero distance");

    a_sat_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[6] && p6_reg.sat |-> &p6_reg.tq)
        else $error("saturated distance is not all ones");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result beat was lost");

endmodule

/* src/rtt_div.sv */
// Pipelined restoring divider that produces one quotient bit per stage.
`timescale 1ns / 1ps

module rtt_div #(
    parameter int MW     = 45,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [MW-1:0]     num,
    input  logic [MW-1:0]     den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [rtt_pkg::DIST_BITS-1:0] quot,
    output logic [SIDE_W-1:0] side_out
);

    localparam int QB   = rtt_pkg::DIST_BITS;
    localparam int FRAC = rtt_pkg::DIST_FRAC_BITS;
    localparam int DVW  = MW + FRAC + QB;

    logic [DVW-1:0]    rem_reg  [QB];
    logic [MW-1:0]     den_reg  [QB];
    logic [QB-1:0]     q_reg    [QB];
    logic [SIDE_W-1:0] side_reg [QB];
    logic              vld_reg  [QB];

    for (genvar j = 0; j < QB; j++) begin : g_step
        localparam int SH = QB - 1 - j;

        logic [DVW-1:0]    rem_in;
        logic [DVW-1:0]    shifted;
        logic [DVW-1:0]    rem_next;
        logic [MW-1:0]     den_in;
        logic [QB-1:0]     q_in;
        logic [QB-1:0]     q_next;
        logic [SIDE_W-1:0] side_w;
        logic              vld_in;

        if (j == 0) begin : g_first
            assign rem_in = DVW'(num) << FRAC;
            assign den_in = den;
            assign q_in   = '0;
            assign side_w = side_in;
            assign vld_in = in_valid;
        end
        else begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign den_in = den_reg[j-1];
            assign q_in   = q_reg[j-1];
            assign side_w = side_reg[j-1];
            assign vld_in = vld_reg[j-1];
        end

        always_comb
        begin
            shifted = DVW'(den_in) << SH;
            if (rem_in >= shifted)
            begin
                rem_next = rem_in - shifted;
                q_next   = q_in | (QB'(1) << SH);
            end
            else
            begin
                rem_next = rem_in;
                q_next   = q_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= rem_next;
                den_reg[j]  <= den_in;
                q_reg[j]    <= q_next;
                side_reg[j] <= side_w;
            end
        end
    end

    assign out_valid = vld_reg[QB-1];
    assign quot      = q_reg[QB-1];
    assign side_out  = side_reg[QB-1];

endmodule
